[rtl/core/sltf_pkg.sv]
package sltf_pkg;

	localparam int MAX_TRACK_HITS = 64;
	localparam int MAX_ECAL_HITS  = 256;

	localparam int COORD_W    = 24;
	localparam int ID_W       = 31;
	localparam int HC_W       = 7;
	localparam int SLOPE_W    = 32;
	localparam int SLOPE_FRAC = 16;
	localparam int CHI_W      = 63;
	localparam int DIST_W     = 24;
	localparam int SUM_W      = 64;
	localparam int WIDE_W     = 128;
	localparam int WIDE_CW    = $clog2(WIDE_W);
	localparam int MUL_W      = COORD_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int D2_W       = PROD_W;
	localparam int SQ_TOP     = ((D2_W - 1) / 2) * 2;
	localparam int N_SUMS     = 8;
	localparam int EPT_W      = 2 * COORD_W;

	localparam int FIT_CW  = $clog2(MAX_TRACK_HITS + 1);
	localparam int ECAL_AW = (MAX_ECAL_HITS > 1) ? $clog2(MAX_ECAL_HITS) : 1;
	localparam int ECAL_CW = $clog2(MAX_ECAL_HITS + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ECAL_Z   = 1'd1;

	localparam logic [1:0] ACT_TRACK  = 2'd0;
	localparam logic [1:0] ACT_ECAL   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	// operands, destinations and modes of the finish product program
	typedef enum logic [4:0] {
		OPD_N, OPD_SZ, OPD_SZZ, OPD_SX, OPD_SY, OPD_SZX, OPD_SZY, OPD_SXX, OPD_SYY,
		OPD_DEN, OPD_NMX, OPD_NBX, OPD_NMY, OPD_NBY, OPD_T, OPD_PZ, OPD_ONE
	} opd_t;

	typedef enum logic [3:0] {
		DST_DEN, DST_NMX, DST_NBX, DST_NMY, DST_NBY, DST_CHI, DST_T, DST_EXN, DST_EYN
	} dst_t;

	typedef enum logic [1:0] {MM_SET, MM_ADD, MM_SUB} mmode_t;

	typedef struct packed {
		opd_t   a;
		opd_t   b;
		dst_t   dst;
		mmode_t mode;
	} mop_t;

	localparam int N_MOPS = 30;
	localparam int MOP_IW = $clog2(N_MOPS);

	function automatic mop_t mop_at(input logic [MOP_IW-1:0] i);
		mop_t m;
		m = '{OPD_ONE, OPD_ONE, DST_T, MM_SET};
		case (i)
			5'd0:  m = '{OPD_N,   OPD_SZZ, DST_DEN, MM_SET};
			5'd1:  m = '{OPD_SZ,  OPD_SZ,  DST_DEN, MM_SUB};
			5'd2:  m = '{OPD_N,   OPD_SZX, DST_NMX, MM_SET};
			5'd3:  m = '{OPD_SZ,  OPD_SX,  DST_NMX, MM_SUB};
			5'd4:  m = '{OPD_SZZ, OPD_SX,  DST_NBX, MM_SET};
			5'd5:  m = '{OPD_SZ,  OPD_SZX, DST_NBX, MM_SUB};
			5'd6:  m = '{OPD_N,   OPD_SZY, DST_NMY, MM_SET};
			5'd7:  m = '{OPD_SZ,  OPD_SY,  DST_NMY, MM_SUB};
			5'd8:  m = '{OPD_SZZ, OPD_SY,  DST_NBY, MM_SET};
			5'd9:  m = '{OPD_SZ,  OPD_SZY, DST_NBY, MM_SUB};
			// x residuals
			5'd10: m = '{OPD_SXX, OPD_DEN, DST_CHI, MM_SET};
			5'd11: m = '{OPD_SZ,  OPD_SX,  DST_T,   MM_SET};
			5'd12: m = '{OPD_T,   OPD_SZX, DST_CHI, MM_ADD};
			5'd13: m = '{OPD_T,   OPD_SZX, DST_CHI, MM_ADD};
			5'd14: m = '{OPD_N,   OPD_SZX, DST_T,   MM_SET};
			5'd15: m = '{OPD_T,   OPD_SZX, DST_CHI, MM_SUB};
			5'd16: m = '{OPD_SZZ, OPD_SX,  DST_T,   MM_SET};
			5'd17: m = '{OPD_T,   OPD_SX,  DST_CHI, MM_SUB};
			// y residuals
			5'd18: m = '{OPD_SYY, OPD_DEN, DST_CHI, MM_ADD};
			5'd19: m = '{OPD_SZ,  OPD_SY,  DST_T,   MM_SET};
			5'd20: m = '{OPD_T,   OPD_SZY, DST_CHI, MM_ADD};
			5'd21: m = '{OPD_T,   OPD_SZY, DST_CHI, MM_ADD};
			5'd22: m = '{OPD_N,   OPD_SZY, DST_T,   MM_SET};
			5'd23: m = '{OPD_T,   OPD_SZY, DST_CHI, MM_SUB};
			5'd24: m = '{OPD_SZZ, OPD_SY,  DST_T,   MM_SET};
			5'd25: m = '{OPD_T,   OPD_SY,  DST_CHI, MM_SUB};
			// extrapolation numerators
			5'd26: m = '{OPD_NMX, OPD_PZ,  DST_EXN, MM_SET};
			5'd27: m = '{OPD_NBX, OPD_ONE, DST_EXN, MM_ADD};
			5'd28: m = '{OPD_NMY, OPD_PZ,  DST_EYN, MM_SET};
			5'd29: m = '{OPD_NBY, OPD_ONE, DST_EYN, MM_ADD};
			default: m = '{OPD_ONE, OPD_ONE, DST_T, MM_SET};
		endcase
		return m;
	endfunction

	// saturate a wide signed value to w bits, result sign-extended to 64
	function automatic logic [63:0] sat_s(input logic [WIDE_W-1:0] v, input int w);
		logic [WIDE_W-1:0] hi;
		logic [63:0]       lim;
		hi  = WIDE_W'($signed(v) >>> (w - 1));
		lim = (64'd1 << (w - 1)) - 64'd1;
		if (hi == '0 || hi == '1)
			return v[63:0];
		else if (v[WIDE_W-1])
			return ~lim;
		return lim;
	endfunction

endpackage

[rtl/core/sltf_ifs.sv]
interface sltf_hit_if;
	import sltf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [ID_W-1:0]           track_id;
	modport source (output valid, action, pos_x, pos_y, pos_z, track_id, input ready);
	modport sink   (input valid, action, pos_x, pos_y, pos_z, track_id, output ready);
endinterface

interface sltf_res_if;
	import sltf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [HC_W-1:0]           hit_count;
	logic signed [SLOPE_W-1:0] slope_x;
	logic signed [COORD_W-1:0] intercept_x;
	logic signed [SLOPE_W-1:0] slope_y;
	logic signed [COORD_W-1:0] intercept_y;
	logic [CHI_W-1:0]          chi_square;
	logic                      ecal_match;
	logic signed [COORD_W-1:0] match_x;
	logic signed [COORD_W-1:0] match_y;
	logic [DIST_W-1:0]         match_distance;
	logic signed [COORD_W-1:0] extrap_x;
	logic signed [COORD_W-1:0] extrap_y;
	modport source (output valid, hit_count, slope_x, intercept_x, slope_y, intercept_y,
		chi_square, ecal_match, match_x, match_y, match_distance, extrap_x, extrap_y,
		input ready);
	modport sink (input valid, hit_count, slope_x, intercept_x, slope_y, intercept_y,
		chi_square, ecal_match, match_x, match_y, match_distance, extrap_x, extrap_y,
		output ready);
endinterface

interface sltf_cfg_if;
	import sltf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/straight_line_track_fit_core.sv]
// Channel  Role    Carries
// hit      sink    action, pos_x, pos_y, pos_z, track_id
// res      source  hit_count, slopes, intercepts, chi_square, match and extrapolation
// cfg      sink    index, data (always ready)
//
// Tracker hit: accept, then 8 steps of the 25x25 multiplier into the moment ring.
// Finish: 30 products on the bit-serial 128-bit shift-add multiplier, up to 7 quotients
// on the restoring divider, a search over the stored calorimeter hits and a square root.
// Reset clears the control and moment state; the calorimeter store is not swept.
// A result waits in the output register; hits are still taken meanwhile, and a finish
// holds before its divisions until the previous result has gone.
module straight_line_track_fit_core (
	input logic       clk,
	input logic       arst_n,
	sltf_hit_if.sink  hit,
	sltf_res_if.source res,
	sltf_cfg_if.sink  cfg
);
	import sltf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_MLOAD, ST_MRUN, ST_MWB, ST_HOLD, ST_DSTART, ST_DWAIT,
		ST_SWAIT, ST_SX, ST_SY, ST_SQRT, ST_DONE
	} state_t;

	typedef enum logic [2:0] {DV_MX, DV_BX, DV_MY, DV_BY, DV_CHI, DV_EX, DV_EY} dsel_t;

	typedef struct packed {
		logic [HC_W-1:0]           hit_count;
		logic signed [SLOPE_W-1:0] slope_x;
		logic signed [COORD_W-1:0] intercept_x;
		logic signed [SLOPE_W-1:0] slope_y;
		logic signed [COORD_W-1:0] intercept_y;
		logic [CHI_W-1:0]          chi_square;
		logic                      ecal_match;
		logic signed [COORD_W-1:0] match_x;
		logic signed [COORD_W-1:0] match_y;
		logic [DIST_W-1:0]         match_distance;
		logic signed [COORD_W-1:0] extrap_x;
		logic signed [COORD_W-1:0] extrap_y;
	} res_t;

	state_t                    state_q;
	dsel_t                     dsel_q;
	logic [FIT_CW-1:0]         fit_cnt_q;
	logic signed [SUM_W-1:0]   ring_q [N_SUMS];
	logic [ECAL_CW-1:0]        ecal_cnt_q;
	logic signed [COORD_W-1:0] plane_z_q;
	logic [ID_W-1:0]           wanted_id_q;
	logic signed [COORD_W-1:0] thr_q;
	logic signed [COORD_W-1:0] hx_q, hy_q, hz_q;
	logic [2:0]                step_q;
	logic [MOP_IW-1:0]         mop_idx_q;
	logic [WIDE_CW-1:0]        bitcnt_q;
	logic [WIDE_W-1:0]         ma_q, mb_q, acc_q;
	logic [WIDE_W-1:0]         den_q, nmx_q, nbx_q, nmy_q, nby_q, chi_q, t_q, exn_q, eyn_q;
	logic [ECAL_CW-1:0]        srch_idx_q;
	logic [D2_W-1:0]           best_q, d2x_q;
	logic [D2_W-1:0]           sv_q, sr_q, sbit_q;
	logic                      res_valid_q;
	res_t                      out_q;

	logic                      hit_acc;
	logic                      ecal_take;
	mop_t                      mop;
	logic [WIDE_W-1:0]         opa, opb, dst_cur, wb_val, div_num;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   addend, sum_raw, acc_sum;
	logic signed [MUL_W-1:0]   dx, dy;
	logic [D2_W-1:0]           d2, best_nx, rb, r_nx;
	logic                      pick;
	logic [ECAL_CW-1:0]        srch_nx;
	logic [EPT_W-1:0]          rd_data;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic                      div_start, div_done;
	logic [WIDE_W-1:0]         div_quo;
	logic [63:0]               sat_slope, sat_pos, sat_chi;
	logic [31:0]               fc32;
	logic [HC_W-1:0]           hc;
	logic                      fit_ok;

	function automatic logic [WIDE_W-1:0] opnd_val(input opd_t c);
		logic [WIDE_W-1:0] v;
		case (c)
			OPD_N:   v = WIDE_W'(fit_cnt_q);
			OPD_SZ:  v = WIDE_W'(ring_q[0]);
			OPD_SZZ: v = WIDE_W'(ring_q[1]);
			OPD_SX:  v = WIDE_W'(ring_q[2]);
			OPD_SY:  v = WIDE_W'(ring_q[3]);
			OPD_SZX: v = WIDE_W'(ring_q[4]);
			OPD_SZY: v = WIDE_W'(ring_q[5]);
			OPD_SXX: v = WIDE_W'(ring_q[6]);
			OPD_SYY: v = WIDE_W'(ring_q[7]);
			OPD_DEN: v = den_q;
			OPD_NMX: v = nmx_q;
			OPD_NBX: v = nbx_q;
			OPD_NMY: v = nmy_q;
			OPD_NBY: v = nby_q;
			OPD_T:   v = t_q;
			OPD_PZ:  v = WIDE_W'(plane_z_q);
			OPD_ONE: v = WIDE_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign hit.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign hit_acc   = hit.valid && hit.ready;
	assign ecal_take = hit_acc && (hit.action == ACT_ECAL) && (hit.pos_z < thr_q) &&
		(ecal_cnt_q < ECAL_CW'(MAX_ECAL_HITS));

	assign mop = mop_at(mop_idx_q);
	assign opa = opnd_val(mop.a);
	assign opb = opnd_val(mop.b);

	always_comb begin
		case (mop.dst)
			DST_DEN: dst_cur = den_q;
			DST_NMX: dst_cur = nmx_q;
			DST_NBX: dst_cur = nbx_q;
			DST_NMY: dst_cur = nmy_q;
			DST_NBY: dst_cur = nby_q;
			DST_CHI: dst_cur = chi_q;
			DST_T:   dst_cur = t_q;
			DST_EXN: dst_cur = exn_q;
			DST_EYN: dst_cur = eyn_q;
			default: dst_cur = '0;
		endcase
		case (mop.mode)
			MM_ADD:  wb_val = dst_cur + acc_q;
			MM_SUB:  wb_val = dst_cur - acc_q;
			default: wb_val = acc_q;
		endcase
	end

	// shared small multiplier: moment terms during a hit, squared distances in the search
	assign rd_x = rd_data[EPT_W-1:COORD_W];
	assign rd_y = rd_data[COORD_W-1:0];
	assign dx   = MUL_W'(out_q.extrap_x) - MUL_W'(rd_x);
	assign dy   = MUL_W'(out_q.extrap_y) - MUL_W'(rd_y);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ACC: begin
				case (step_q)
					3'd0: begin mul_a = MUL_W'(hz_q); mul_b = MUL_W'(1); end
					3'd1: begin mul_a = MUL_W'(hz_q); mul_b = MUL_W'(hz_q); end
					3'd2: begin mul_a = MUL_W'(hx_q); mul_b = MUL_W'(1); end
					3'd3: begin mul_a = MUL_W'(hy_q); mul_b = MUL_W'(1); end
					3'd4: begin mul_a = MUL_W'(hz_q); mul_b = MUL_W'(hx_q); end
					3'd5: begin mul_a = MUL_W'(hz_q); mul_b = MUL_W'(hy_q); end
					3'd6: begin mul_a = MUL_W'(hx_q); mul_b = MUL_W'(hx_q); end
					default: begin mul_a = MUL_W'(hy_q); mul_b = MUL_W'(hy_q); end
				endcase
			end
			ST_SX: begin mul_a = dx; mul_b = dx; end
			ST_SY: begin mul_a = dy; mul_b = dy; end
			default: ;
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign addend  = SUM_W'(prod);
	assign sum_raw = ring_q[0] + addend;

	always_comb begin
		acc_sum = sum_raw;
		if (ring_q[0][SUM_W-1] == addend[SUM_W-1] && sum_raw[SUM_W-1] != addend[SUM_W-1])
			acc_sum = addend[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
	end

	assign d2      = d2x_q + D2_W'(prod);
	assign pick    = (srch_idx_q == '0) || (d2 < best_q);
	assign best_nx = pick ? d2 : best_q;
	assign srch_nx = srch_idx_q + 1'b1;

	assign rb   = sr_q + sbit_q;
	assign r_nx = (sv_q >= rb) ? (sr_q >> 1) + sbit_q : (sr_q >> 1);

	always_comb begin
		case (dsel_q)
			DV_MX:   div_num = nmx_q << SLOPE_FRAC;
			DV_BX:   div_num = nbx_q;
			DV_MY:   div_num = nmy_q << SLOPE_FRAC;
			DV_BY:   div_num = nby_q;
			DV_CHI:  div_num = chi_q;
			DV_EX:   div_num = exn_q;
			DV_EY:   div_num = eyn_q;
			default: div_num = '0;
		endcase
	end

	assign div_start = (state_q == ST_DSTART);
	assign sat_slope = sat_s(div_quo, SLOPE_W);
	assign sat_pos   = sat_s(div_quo, COORD_W);
	assign sat_chi   = sat_s(div_quo, SUM_W);

	assign fc32   = 32'(fit_cnt_q);
	assign hc     = ((fc32 >> HC_W) != 0) ? '1 : fc32[HC_W-1:0];
	assign fit_ok = (fit_cnt_q >= FIT_CW'(2)) && !den_q[WIDE_W-1] && (den_q != '0);

	sltf_ram #(
		.WIDTH (EPT_W),
		.DEPTH (MAX_ECAL_HITS)
	) u_ecal_ram (
		.clk   (clk),
		.we    (ecal_take),
		.waddr (ecal_cnt_q[ECAL_AW-1:0]),
		.wdata ({hit.pos_x, hit.pos_y}),
		.raddr (srch_idx_q[ECAL_AW-1:0]),
		.rdata (rd_data)
	);

	sltf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dsel_q      <= DV_MX;
			fit_cnt_q   <= '0;
			for (int i = 0; i < N_SUMS; i++)
				ring_q[i] <= '0;
			ecal_cnt_q  <= '0;
			plane_z_q   <= '0;
			wanted_id_q <= ID_W'(1);
			thr_q       <= '0;
			step_q      <= '0;
			mop_idx_q   <= '0;
			bitcnt_q    <= '0;
			srch_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_TRACK_ID: wanted_id_q <= cfg.data[ID_W-1:0];
					CFG_ECAL_Z:   thr_q       <= cfg.data[COORD_W-1:0];
				endcase
			end

			if (res.valid && res.ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (hit_acc) begin
						hx_q <= hit.pos_x;
						hy_q <= hit.pos_y;
						hz_q <= hit.pos_z;
						if (hit.action == ACT_TRACK && hit.track_id == wanted_id_q &&
							fit_cnt_q < FIT_CW'(MAX_TRACK_HITS)) begin
							step_q  <= '0;
							state_q <= ST_ACC;
						end else if (hit.action == ACT_FINISH) begin
							mop_idx_q <= '0;
							state_q   <= ST_MLOAD;
						end
						if (ecal_take) begin
							if (ecal_cnt_q == '0)
								plane_z_q <= hit.pos_z;
							ecal_cnt_q <= ecal_cnt_q + 1'b1;
						end
					end
				end
				ST_ACC: begin
					// the ring turns once per term, so after eight it is back in order
					for (int i = 0; i < N_SUMS - 1; i++)
						ring_q[i] <= ring_q[i+1];
					ring_q[N_SUMS-1] <= acc_sum;
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						fit_cnt_q <= fit_cnt_q + 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_MLOAD: begin
					ma_q     <= opa;
					mb_q     <= opb;
					acc_q    <= '0;
					bitcnt_q <= '0;
					state_q  <= ST_MRUN;
				end
				ST_MRUN: begin
					if (mb_q[0])
						acc_q <= acc_q + ma_q;
					ma_q     <= ma_q << 1;
					mb_q     <= mb_q >> 1;
					bitcnt_q <= bitcnt_q + 1'b1;
					if (bitcnt_q == WIDE_CW'(WIDE_W - 1))
						state_q <= ST_MWB;
				end
				ST_MWB: begin
					case (mop.dst)
						DST_DEN: den_q <= wb_val;
						DST_NMX: nmx_q <= wb_val;
						DST_NBX: nbx_q <= wb_val;
						DST_NMY: nmy_q <= wb_val;
						DST_NBY: nby_q <= wb_val;
						DST_CHI: chi_q <= wb_val;
						DST_EXN: exn_q <= wb_val;
						DST_EYN: eyn_q <= wb_val;
						default: t_q   <= wb_val;
					endcase
					if (mop_idx_q == MOP_IW'(N_MOPS - 1)) begin
						state_q <= ST_HOLD;
					end else begin
						mop_idx_q <= mop_idx_q + 1'b1;
						state_q   <= ST_MLOAD;
					end
				end
				ST_HOLD: begin
					if (!res_valid_q) begin
						out_q   <= '{hit_count: hc, default: '0};
						dsel_q  <= DV_MX;
						state_q <= fit_ok ? ST_DSTART : ST_DONE;
					end
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						dsel_q <= dsel_t'(dsel_q + 1'b1);
						case (dsel_q)
							DV_MX: begin
								out_q.slope_x <= sat_slope[SLOPE_W-1:0];
								state_q       <= ST_DSTART;
							end
							DV_BX: begin
								out_q.intercept_x <= sat_pos[COORD_W-1:0];
								state_q           <= ST_DSTART;
							end
							DV_MY: begin
								out_q.slope_y <= sat_slope[SLOPE_W-1:0];
								state_q       <= ST_DSTART;
							end
							DV_BY: begin
								out_q.intercept_y <= sat_pos[COORD_W-1:0];
								state_q           <= ST_DSTART;
							end
							DV_CHI: begin
								out_q.chi_square <= div_quo[WIDE_W-1] ? '0 : sat_chi[CHI_W-1:0];
								state_q <= (ecal_cnt_q == '0) ? ST_DONE : ST_DSTART;
							end
							DV_EX: begin
								out_q.extrap_x <= sat_pos[COORD_W-1:0];
								state_q        <= ST_DSTART;
							end
							default: begin
								out_q.extrap_y   <= sat_pos[COORD_W-1:0];
								out_q.ecal_match <= 1'b1;
								srch_idx_q       <= '0;
								state_q          <= ST_SWAIT;
							end
						endcase
					end
				end
				ST_SWAIT: state_q <= ST_SX;
				ST_SX: begin
					d2x_q   <= D2_W'(prod);
					state_q <= ST_SY;
				end
				ST_SY: begin
					if (pick) begin
						best_q        <= d2;
						out_q.match_x <= rd_x;
						out_q.match_y <= rd_y;
					end
					srch_idx_q <= srch_nx;
					if (srch_nx == ecal_cnt_q) begin
						sv_q    <= best_nx;
						sr_q    <= '0;
						sbit_q  <= D2_W'(1) << SQ_TOP;
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_SWAIT;
					end
				end
				ST_SQRT: begin
					if (sv_q >= rb)
						sv_q <= sv_q - rb;
					sr_q   <= r_nx;
					sbit_q <= sbit_q >> 2;
					if (sbit_q == D2_W'(1)) begin
						out_q.match_distance <= ((r_nx >> DIST_W) != '0) ? '1 : r_nx[DIST_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					fit_cnt_q   <= '0;
					for (int i = 0; i < N_SUMS; i++)
						ring_q[i] <= '0;
					ecal_cnt_q  <= '0;
					plane_z_q   <= '0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid          = res_valid_q;
	assign res.hit_count      = out_q.hit_count;
	assign res.slope_x        = out_q.slope_x;
	assign res.intercept_x    = out_q.intercept_x;
	assign res.slope_y        = out_q.slope_y;
	assign res.intercept_y    = out_q.intercept_y;
	assign res.chi_square     = out_q.chi_square;
	assign res.ecal_match     = out_q.ecal_match;
	assign res.match_x        = out_q.match_x;
	assign res.match_y        = out_q.match_y;
	assign res.match_distance = out_q.match_distance;
	assign res.extrap_x       = out_q.extrap_x;
	assign res.extrap_y       = out_q.extrap_y;

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the closing step");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(ecal_cnt_q <= ECAL_CW'(MAX_ECAL_HITS)) && (fit_cnt_q <= FIT_CW'(MAX_TRACK_HITS)))
		else $error("hit counter beyond store depth");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SY) |-> (srch_idx_q < ecal_cnt_q))
		else $error("search reads past the stored calorimeter hits");

endmodule

[rtl/core/sltf_ram.sv]
module sltf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/sltf_div.sv]
module sltf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sltf_pkg::WIDE_W-1:0] num,
	input  logic [sltf_pkg::WIDE_W-1:0] den,
	output logic                        done,
	output logic [sltf_pkg::WIDE_W-1:0] quo
);
	import sltf_pkg::*;

	typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_RND} dstate_t;

	dstate_t             st_q;
	logic [WIDE_CW-1:0]  cnt_q;
	logic                neg_q;
	logic                done_q;
	logic [WIDE_W-1:0]   mag_q;
	logic [WIDE_W-1:0]   rem_q;
	logic [WIDE_W-1:0]   quo_q;
	logic [WIDE_W-1:0]   r2;
	logic                ge;
	logic                up;
	logic [WIDE_W-1:0]   qr;

	// remainder stays below den < 2^127, so its top bit is always clear
	assign r2 = {rem_q[WIDE_W-2:0], mag_q[WIDE_W-1]};
	assign ge = (r2 >= den);
	assign up = ({rem_q, 1'b0} >= {1'b0, den});
	assign qr = mag_q + WIDE_W'(up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				DV_IDLE: begin
					if (start) begin
						neg_q <= num[WIDE_W-1];
						mag_q <= num[WIDE_W-1] ? -num : num;
						rem_q <= '0;
						cnt_q <= '0;
						st_q  <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q <= ge ? r2 - den : r2;
					mag_q <= {mag_q[WIDE_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == WIDE_CW'(WIDE_W - 1))
						st_q <= DV_RND;
				end
				DV_RND: begin
					quo_q  <= neg_q ? -qr : qr;
					done_q <= 1'b1;
					st_q   <= DV_IDLE;
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[dv/sltf_tb_ifs.sv]
`timescale 1ns / 1ps

// Bundles of a line-fit request and a line-fit result as the bench sees them
package sltf_tb_types;
	import sltf_pkg::*;

	typedef struct {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [ID_W-1:0]           id;
	} hit_req_t;

	typedef struct {
		logic [HC_W-1:0]           hit_count;
		logic signed [SLOPE_W-1:0] slope_x;
		logic signed [COORD_W-1:0] intercept_x;
		logic signed [SLOPE_W-1:0] slope_y;
		logic signed [COORD_W-1:0] intercept_y;
		logic [CHI_W-1:0]          chi_square;
		logic                      ecal_match;
		logic signed [COORD_W-1:0] match_x;
		logic signed [COORD_W-1:0] match_y;
		logic [DIST_W-1:0]         match_distance;
		logic signed [COORD_W-1:0] extrap_x;
		logic signed [COORD_W-1:0] extrap_y;
	} fit_res_t;
endpackage

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import sltf_pkg::*;
	import sltf_tb_types::*;

	localparam int HOLD_CYCLES   = 20000;
	localparam int IDLE_LIMIT    = 60000;
	localparam int SETTLE_CYCLES = 40;

	localparam logic signed [COORD_W-1:0] CMAX = 24'sh7fffff;
	localparam logic signed [COORD_W-1:0] CMIN = -24'sh800000;
	localparam logic [ID_W-1:0]           IDMAX = 31'h7fffffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	sltf_hit_if hit ();
	sltf_res_if res ();
	sltf_cfg_if cfg ();

	straight_line_track_fit_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hit    (hit.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	// shadow of the block: registers and event moments
	logic [ID_W-1:0]           m_track_id;
	logic signed [COORD_W-1:0] m_ecal_thr;
	int                        m_fit_n;
	logic signed [63:0]        m_sums [N_SUMS];
	logic signed [COORD_W-1:0] m_ecal_x [MAX_ECAL_HITS];
	logic signed [COORD_W-1:0] m_ecal_y [MAX_ECAL_HITS];
	int                        m_ecal_n;
	logic signed [COORD_W-1:0] m_plane_z;

	fit_res_t expected_fits [$];
	int errors = 0;
	int fits_seen = 0;
	int matched_fits = 0;
	int settings_run = 0;
	int hold_reqs = 0;

	function automatic void queue_fit(fit_res_t f);
		expected_fits = {expected_fits, f};
	endfunction

	function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7fffffff_ffffffff) return 64'sh7fffffff_ffffffff;
		if (s < -65'sh0_80000000_00000000) return 64'sh80000000_00000000;
		return s[63:0];
	endfunction

	// quotient rounded to nearest, halves away from zero; den is positive
	function automatic logic signed [127:0] round_div(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] mag, q, r;
		mag = num[127] ? -num : num;
		q = mag / den;
		r = mag % den;
		if ({r, 1'b0} >= {1'b0, den}) q = q + 1;
		return num[127] ? -q : q;
	endfunction

	function automatic logic signed [63:0] clamp_to(logic signed [127:0] v, longint lo, longint hi);
		if (v < 128'(lo)) return lo;
		if (v > 128'(hi)) return hi;
		return v[63:0];
	endfunction

	function automatic logic signed [127:0] wide(logic signed [63:0] v);
		return 128'(v);
	endfunction

	// residual sum of one coordinate, scaled by the determinant
	function automatic logic signed [127:0] resid_num(logic signed [127:0] n, den, sz, szz,
			sc, szc, scc);
		return scc * den - n * szc * szc + 2 * sz * sc * szc - szz * sc * sc;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void clear_event();
		m_fit_n = 0;
		for (int i = 0; i < N_SUMS; i++) m_sums[i] = 0;
		m_ecal_n = 0;
		m_plane_z = 0;
	endfunction

	function automatic fit_res_t solve_event();
		fit_res_t f;
		logic signed [127:0] n, den, sz, szz, sx, sy, szx, szy, sxx, syy;
		logic signed [127:0] nmx, nbx, nmy, nby, chi;
		logic signed [63:0] ex, ey, dx, dy;
		logic [63:0] d2, best, d;
		int pick;
		f = '{default: '0};
		f.hit_count = (m_fit_n > 127) ? 7'd127 : HC_W'(m_fit_n);
		n = 128'(m_fit_n);
		sz = wide(m_sums[0]); szz = wide(m_sums[1]); sx = wide(m_sums[2]);
		sy = wide(m_sums[3]); szx = wide(m_sums[4]); szy = wide(m_sums[5]);
		sxx = wide(m_sums[6]); syy = wide(m_sums[7]);
		den = n * szz - sz * sz;
		if (m_fit_n >= 2 && den > 0) begin
			nmx = n * szx - sz * sx;
			nbx = szz * sx - sz * szx;
			nmy = n * szy - sz * sy;
			nby = szz * sy - sz * szy;
			chi = resid_num(n, den, sz, szz, sx, szx, sxx) + resid_num(n, den, sz, szz, sy, szy, syy);
			f.slope_x = SLOPE_W'(clamp_to(round_div(nmx * 65536, den), -64'sd2147483648,
				64'sd2147483647));
			f.intercept_x = COORD_W'(clamp_to(round_div(nbx, den), -8388608, 8388607));
			f.slope_y = SLOPE_W'(clamp_to(round_div(nmy * 65536, den), -64'sd2147483648,
				64'sd2147483647));
			f.intercept_y = COORD_W'(clamp_to(round_div(nby, den), -8388608, 8388607));
			f.chi_square = chi[127] ? '0 :
				CHI_W'(clamp_to(round_div(chi, den), 0, 64'sh7fffffff_ffffffff));
			if (m_ecal_n > 0) begin
				ex = clamp_to(round_div(nmx * wide(64'(m_plane_z)) + nbx, den), -8388608, 8388607);
				ey = clamp_to(round_div(nmy * wide(64'(m_plane_z)) + nby, den), -8388608, 8388607);
				best = 0;
				pick = 0;
				for (int i = 0; i < m_ecal_n; i++) begin
					dx = ex - 64'(m_ecal_x[i]);
					dy = ey - 64'(m_ecal_y[i]);
					d2 = dx * dx + dy * dy;
					if (i == 0 || d2 < best) begin
						best = d2;
						pick = i;
					end
				end
				d = floor_sqrt(best);
				f.ecal_match = 1'b1;
				f.match_x = m_ecal_x[pick];
				f.match_y = m_ecal_y[pick];
				f.match_distance = (d > 64'd16777215) ? 24'hffffff : d[23:0];
				f.extrap_x = ex[23:0];
				f.extrap_y = ey[23:0];
			end
		end
		clear_event();
		return f;
	endfunction

	// advances the shadow by one request; returns 1 with a result on finish
	function automatic bit apply_request(hit_req_t h, output fit_res_t f);
		logic signed [63:0] x, y, z;
		x = 64'(h.x); y = 64'(h.y); z = 64'(h.z);
		f = '{default: '0};
		case (h.action)
			ACT_TRACK: if (h.id == m_track_id && m_fit_n < MAX_TRACK_HITS) begin
				m_sums[0] = sat_sum(m_sums[0], z);
				m_sums[1] = sat_sum(m_sums[1], z * z);
				m_sums[2] = sat_sum(m_sums[2], x);
				m_sums[3] = sat_sum(m_sums[3], y);
				m_sums[4] = sat_sum(m_sums[4], z * x);
				m_sums[5] = sat_sum(m_sums[5], z * y);
				m_sums[6] = sat_sum(m_sums[6], x * x);
				m_sums[7] = sat_sum(m_sums[7], y * y);
				m_fit_n++;
			end
			ACT_ECAL: if (h.z < m_ecal_thr && m_ecal_n < MAX_ECAL_HITS) begin
				if (m_ecal_n == 0) m_plane_z = h.z;
				m_ecal_x[m_ecal_n] = h.x;
				m_ecal_y[m_ecal_n] = h.y;
				m_ecal_n++;
			end
			ACT_FINISH: begin
				f = solve_event();
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// result checker
	task automatic field_chk(string name, logic [63:0] got, logic [63:0] want, inout bit bad);
		if (got !== want) begin
			bad = 1'b1;
			if (errors < 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		fit_res_t w;
		bit bad;
		if (arst_n && res.valid && res.ready) begin
			bad = 1'b0;
			if (expected_fits.size() == 0) begin
				if (errors < 10) $display("%0t: result with none outstanding", $realtime);
				errors++;
			end else begin
				w = expected_fits.pop_front();
				field_chk("hit_count", res.hit_count, w.hit_count, bad);
				field_chk("slope_x", res.slope_x, w.slope_x, bad);
				field_chk("intercept_x", res.intercept_x, w.intercept_x, bad);
				field_chk("slope_y", res.slope_y, w.slope_y, bad);
				field_chk("intercept_y", res.intercept_y, w.intercept_y, bad);
				field_chk("chi_square", res.chi_square, w.chi_square, bad);
				field_chk("ecal_match", res.ecal_match, w.ecal_match, bad);
				field_chk("match_x", res.match_x, w.match_x, bad);
				field_chk("match_y", res.match_y, w.match_y, bad);
				field_chk("match_distance", res.match_distance, w.match_distance, bad);
				field_chk("extrap_x", res.extrap_x, w.extrap_x, bad);
				field_chk("extrap_y", res.extrap_y, w.extrap_y, bad);
				if (bad) errors++;
				fits_seen++;
				if (w.ecal_match) matched_fits++;
			end
		end
	end

	// receiver: random stall pattern, stretches with none, and long hold-offs on request
	int hold_left = 0;
	int hold_done = 0;
	int pat_age = 0;
	logic [31:0] stall_pat = '1;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (hold_done < hold_reqs) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else begin
			res.ready <= stall_pat[0];
			if (pat_age == 63) begin
				pat_age <= 0;
				stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : $urandom;
			end else begin
				pat_age <= pat_age + 1;
				stall_pat <= {stall_pat[0], stall_pat[31:1]};
			end
		end
	end

	// watchdog on cycles with no request or result moving
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((hit.valid && hit.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sender
	int burst_left = 0;

	task automatic send_hit(hit_req_t h, bit literal = 0, fit_res_t lit = '{default: '0});
		fit_res_t f;
		int gap;
		hit.valid <= 1'b1;
		hit.action <= h.action;
		hit.pos_x <= h.x;
		hit.pos_y <= h.y;
		hit.pos_z <= h.z;
		hit.track_id <= h.id;
		do @(posedge clk); while (!hit.ready);
		if (apply_request(h, f)) queue_fit(literal ? lit : f);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				hit.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		hit.valid <= 1'b0;
		while (expected_fits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_TRACK_ID) m_track_id = d;
		else m_ecal_thr = d[COORD_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] clip(longint v);
		if (v > 8388607) return CMAX;
		if (v < -8388608) return CMIN;
		return COORD_W'(v);
	endfunction

	// calorimeter z, mostly one that passes the threshold where one can
	function automatic logic signed [COORD_W-1:0] ecal_z();
		longint span;
		if (m_ecal_thr == CMIN || $urandom_range(0, 7) == 0) return COORD_W'($urandom);
		span = longint'(m_ecal_thr) + 8388608;
		return clip(longint'(m_ecal_thr) - 1 - longint'($urandom % span));
	endfunction

	task automatic random_event();
		hit_req_t h;
		longint mx, my, bx, by, zz;
		int ntrk, necal, noise, shift;
		bit messy;
		messy = ($urandom_range(0, 6) == 0);
		ntrk = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
		necal = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		mx = $signed($urandom) >>> $urandom_range(8, 31);
		my = $signed($urandom) >>> $urandom_range(8, 31);
		bx = $signed($urandom) >>> 9;
		by = $signed($urandom) >>> 9;
		shift = $urandom_range(4, 16);
		noise = $urandom_range(0, 3);
		while (ntrk + necal > 0) begin
			if (messy && $urandom_range(0, 3) == 0) begin
				h.action = 2'($urandom);
				if (h.action == ACT_FINISH) h.action = ACT_TRACK;
				h.x = COORD_W'($urandom); h.y = COORD_W'($urandom); h.z = COORD_W'($urandom);
				h.id = ($urandom_range(0, 1)) ? m_track_id : 31'($urandom);
			end else if (ntrk > 0 && (necal == 0 || $urandom_range(0, 2) != 0)) begin
				ntrk--;
				zz = ($signed($urandom) >>> (8 + shift)) * 256;
				h.action = ACT_TRACK;
				h.z = clip(zz);
				h.x = clip(bx + ((mx * zz) >>> 16) + ($signed($urandom) >>> (31 - noise * 4)));
				h.y = clip(by + ((my * zz) >>> 16) + ($signed($urandom) >>> (31 - noise * 4)));
				h.id = ($urandom_range(0, 9) == 0) ? 31'($urandom) : m_track_id;
			end else begin
				necal--;
				h.action = ACT_ECAL;
				h.z = ecal_z();
				h.x = clip(bx + ($signed($urandom) >>> 12));
				h.y = clip(by + ($signed($urandom) >>> 12));
				h.id = 31'($urandom);
			end
			send_hit(h);
		end
		h = '{ACT_FINISH, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			31'($urandom)};
		send_hit(h);
	endtask

	typedef struct {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] x, y, z;
		logic [ID_W-1:0]           id;
		int                        reps;
		bit                        literal;
		logic [HC_W-1:0]           lit_hits;
	} stim_row_t;

	// directed rows; repeated rows step x, y and z (y and z downwards) so stored hits differ.
	// Literal rows: finishes whose whole result is zero apart from the hit count.
	stim_row_t dir_rows [] = '{
		'{ACT_FINISH, 0, 0, 0, 0, 1, 1, 0},
		'{ACT_TRACK, CMAX, CMIN, 100, 1, 1, 0, 0},
		'{ACT_FINISH, 0, 0, 0, 0, 1, 1, 1},
		'{ACT_TRACK, 5, 7, 300, 1, 1, 0, 0},
		'{ACT_TRACK, -9, 4, 300, 1, 1, 0, 0},
		'{ACT_ECAL, 11, 12, -1, 0, 1, 0, 0},
		'{ACT_FINISH, 0, 0, 0, 0, 1, 1, 2},
		'{ACT_TRACK, 1, 1, 5, 0, 1, 0, 0},
		'{ACT_TRACK, 1, 1, 6, IDMAX, 1, 0, 0},
		'{2'd3, CMAX, CMAX, CMAX, IDMAX, 1, 0, 0},
		'{ACT_FINISH, CMAX, CMAX, CMAX, IDMAX, 1, 1, 0},
		'{ACT_TRACK, CMAX, CMIN, CMIN, 1, 1, 0, 0},
		'{ACT_TRACK, CMIN, CMAX, CMAX, 1, 1, 0, 0},
		'{ACT_TRACK, 0, 0, 0, 1, 1, 0, 0},
		'{ACT_ECAL, CMIN, CMAX, CMIN, 0, 1, 0, 0},
		'{ACT_ECAL, CMAX, CMIN, -5, 0, 1, 0, 0},
		'{ACT_ECAL, CMAX, CMIN, 0, 0, 1, 0, 0},
		'{ACT_FINISH, 0, 0, 0, 0, 1, 0, 0},
		// equal distances: both stored hits sit symmetric about the line
		'{ACT_TRACK, 0, 0, -1000, 1, 1, 0, 0},
		'{ACT_TRACK, 0, 0, 1000, 1, 1, 0, 0},
		'{ACT_ECAL, 500, 0, -2000, 0, 1, 0, 0},
		'{ACT_ECAL, -500, 0, -2000, 0, 1, 0, 0},
		'{ACT_FINISH, 0, 0, 0, 0, 1, 0, 0},
		// overfull stores
		'{ACT_TRACK, -4000, 2000, -30000, 1, 70, 0, 0},
		'{ACT_ECAL, -9000, 3000, -7, 0, 260, 0, 0},
		'{ACT_FINISH, 0, 0, 0, 0, 1, 0, 0}
	};

	initial begin
		hit_req_t h;
		fit_res_t lit;
		hit.valid = 1'b0; hit.action = '0; hit.pos_x = '0; hit.pos_y = '0;
		hit.pos_z = '0; hit.track_id = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		res.ready = 1'b0;
		m_track_id = 1;
		m_ecal_thr = 0;
		clear_event();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				h = '{dir_rows[r].action, dir_rows[r].x + 24'(k * 37), dir_rows[r].y - 24'(k * 53),
					dir_rows[r].z - 24'(k * 211), dir_rows[r].id};
				lit = '{default: '0};
				lit.hit_count = dir_rows[r].lit_hits;
				send_hit(h, dir_rows[r].literal, lit);
			end
		end
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_TRACK_ID, 0); write_reg(CFG_ECAL_Z, 31'(CMAX)); end
				1: begin write_reg(CFG_TRACK_ID, IDMAX); write_reg(CFG_ECAL_Z, 31'(CMIN)); end
				5: begin write_reg(CFG_TRACK_ID, 1); write_reg(CFG_ECAL_Z, 0); end
				default: begin
					write_reg(CFG_TRACK_ID, 31'($urandom));
					write_reg(CFG_ECAL_Z, 31'(24'($signed($urandom) >>> 8)));
				end
			endcase
			settings_run++;
			for (int e = 0; e < 28; e++) begin
				// fill the block up behind a stalled receiver
				if (ph == 2 && e == 3) hold_reqs++;
				// sender pause until the block has emptied out
				if (ph == 3 && e == 10) settle();
				random_event();
			end
			settle();
		end

		$display("Line fits checked: %0d, %0d of them matched to a calorimeter hit.", fits_seen,
			matched_fits);
		$display("Register settings exercised: %0d; mismatching results: %0d.", settings_run + 1,
			errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
